### src/qkvg_pkg.sv
// qkvg_pkg: widths, register indexes, part kinds and the emitter item type
// for the qkv head tile address generator; no dependencies
package qkvg_pkg;

	// field and register widths
	localparam int UNIT_W = 32;
	localparam int TILE_W = 32;
	localparam int PER_W = 7;
	localparam int GRP_W = 7;
	localparam int TPH_W = 5;
	localparam int ROW_W = 16;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// derived widths
	localparam int HEADS_W = PER_W + GRP_W;
	localparam int QTOT_W = HEADS_W + TPH_W;
	localparam int KVTOT_W = GRP_W + TPH_W;
	localparam int KOFS_W = QTOT_W + 1;
	localparam int VOFS_W = QTOT_W + 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_Q_HEADS_PER_GROUP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KV_GROUP_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_HEAD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH_TILES = 2'd3;

	// configuration reset values
	localparam logic [PER_W-1:0] RST_Q_HEADS_PER_GROUP = 7'd1;
	localparam logic [GRP_W-1:0] RST_KV_GROUP_COUNT = 7'd1;
	localparam logic [TPH_W-1:0] RST_TILES_PER_HEAD = 5'd1;
	localparam logic [ROW_W-1:0] RST_ROW_WIDTH_TILES = 16'd3;

	typedef enum logic [KIND_W-1:0] {
		PART_Q = 2'd0,
		PART_K = 2'd1,
		PART_V = 2'd2
	} part_kind_t;

	// one work unit as handed to the emitter
	typedef struct packed {
		logic [TILE_W-1:0] q_start;
		logic [TILE_W-1:0] k_start;
		logic [TILE_W-1:0] v_start;
		logic [TPH_W-1:0]  tiles;
		logic              first;
	} emit_item_t;

endpackage

### src/qkvg_if.sv
// qkvg_in_if and qkvg_out_if: valid/ready request channels of the generator
// depends on qkvg_pkg for payload widths
interface qkvg_in_if;
	logic                        valid;
	logic                        ready;
	logic [qkvg_pkg::UNIT_W-1:0] work_unit_index;

	modport source (output valid, output work_unit_index, input ready);
	modport sink (input valid, input work_unit_index, output ready);
endinterface

interface qkvg_out_if;
	logic                        valid;
	logic                        ready;
	logic [qkvg_pkg::TILE_W-1:0] tile_index;
	logic [qkvg_pkg::KIND_W-1:0] part_kind;
	logic                        last_of_run;

	modport source (output valid, output tile_index, output part_kind, output last_of_run,
		input ready);
	modport sink (input valid, input tile_index, input part_kind, input last_of_run,
		output ready);
endinterface

### src/qkvg_div_pipe.sv
// qkvg_div_pipe: pipelined restoring divider, STEP quotient bits per stage,
// with a sideband carried alongside; no package dependencies
module qkvg_div_pipe #(
	parameter int N = 32,
	parameter int D = 14,
	parameter int STEP = 4,
	parameter int SW = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	input  logic [SW-1:0] side_i,
	output logic         out_valid,
	output logic [N-1:0] quotient,
	output logic [D-1:0] remainder,
	output logic [SW-1:0] side_o
);

	localparam int STAGES = (N + STEP - 1) / STEP;
	localparam int PAD = STAGES * STEP;

	logic [STAGES-1:0] vld_s;
	logic [D-1:0]      rem_s [STAGES];
	logic [PAD-1:0]    quo_s [STAGES];
	logic [SW-1:0]     side_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic          vld_in;
		logic [D-1:0]  rem_in;
		logic [PAD-1:0] quo_in;
		logic [SW-1:0] side_in;
		logic [D-1:0]  rem_nx;
		logic [PAD-1:0] quo_nx;

		if (g == 0) begin : g_head
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign quo_in = PAD'(dividend);
			assign side_in = side_i;
		end else begin : g_body
			assign vld_in = vld_s[g-1];
			assign rem_in = rem_s[g-1];
			assign quo_in = quo_s[g-1];
			assign side_in = side_s[g-1];
		end

		// shift-subtract steps of this stage
		always_comb begin
			logic [D:0] trial;
			logic       ge;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int k = 0; k < STEP; k++) begin
				trial = {rem_nx, quo_nx[PAD-1]};
				ge = trial >= {1'b0, divisor};
				quo_nx = {quo_nx[PAD-2:0], ge};
				rem_nx = ge ? D'(trial - {1'b0, divisor}) : trial[D-1:0];
			end
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= vld_in;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g] <= rem_nx;
				quo_s[g] <= quo_nx;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign quotient = quo_s[STAGES-1][N-1:0];
	assign remainder = rem_s[STAGES-1];
	assign side_o = side_s[STAGES-1];

endmodule

### src/qkvg_emit.sv
// qkvg_emit: expands a work unit into q (plus k, v for first heads) tile runs,
// one result per unstalled cycle via output register; uses qkvg_pkg, qkvg_if
module qkvg_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  qkvg_pkg::emit_item_t item,
	qkvg_out_if.source           tile_ch
);

	logic                               busy_q;
	qkvg_pkg::part_kind_t               kind_q;
	logic                               first_q;
	logic [qkvg_pkg::TPH_W-1:0]         idx_q;
	logic [qkvg_pkg::TPH_W-1:0]         tiles_q;
	logic [qkvg_pkg::TILE_W-1:0]        tile_q;
	logic [qkvg_pkg::TILE_W-1:0]        k_start_q;
	logic [qkvg_pkg::TILE_W-1:0]        v_start_q;
	logic                               out_valid_q;
	logic [qkvg_pkg::TILE_W-1:0]        out_tile_q;
	qkvg_pkg::part_kind_t               out_kind_q;
	logic                               out_last_q;

	logic load;
	logic run_end;
	logic final_res;
	logic take;

	// result slot free and a tile pending
	assign load = busy_q && (!out_valid_q || tile_ch.ready);
	assign run_end = idx_q == qkvg_pkg::TPH_W'(tiles_q - 1'b1);
	assign final_res = run_end && (kind_q == qkvg_pkg::PART_V ||
		(kind_q == qkvg_pkg::PART_Q && !first_q));
	assign in_ready = !busy_q || (load && final_res);
	assign take = in_valid && in_ready;

	// control: busy flag, current run kind, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= qkvg_pkg::PART_Q;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= item.tiles != '0;
				kind_q <= qkvg_pkg::PART_Q;
			end else if (load) begin
				if (final_res) begin
					busy_q <= 1'b0;
				end else if (run_end) begin
					kind_q <= (kind_q == qkvg_pkg::PART_Q) ? qkvg_pkg::PART_K
						: qkvg_pkg::PART_V;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tile_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// run position and tile counter
	always_ff @(posedge clk) begin
		if (take) begin
			idx_q <= '0;
			tiles_q <= item.tiles;
			first_q <= item.first;
			tile_q <= item.q_start;
			k_start_q <= item.k_start;
			v_start_q <= item.v_start;
		end else if (load) begin
			if (run_end) begin
				idx_q <= '0;
				tile_q <= (kind_q == qkvg_pkg::PART_Q) ? k_start_q : v_start_q;
			end else begin
				idx_q <= idx_q + 1'b1;
				tile_q <= tile_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_tile_q <= tile_q;
			out_kind_q <= kind_q;
			out_last_q <= final_res;
		end
	end

	assign tile_ch.valid = out_valid_q;
	assign tile_ch.tile_index = out_tile_q;
	assign tile_ch.part_kind = out_kind_q;
	assign tile_ch.last_of_run = out_last_q;

	// a run in progress never has zero length
	a_busy_tiles: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> tiles_q != '0)
		else $error("emitter busy with empty run");

	// position stays inside the run
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < tiles_q)
		else $error("emitter index past run length");

	// k and v runs only for the first head of a group
	a_kv_first: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && kind_q != qkvg_pkg::PART_Q) |-> first_q)
		else $error("key/value run for non-first head");

	// a blocked emitter holds its position
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !load) |=> ($stable(tile_q) && $stable(idx_q) && busy_q))
		else $error("emitter moved while output blocked");

endmodule

### src/qkv_head_tile_address_generator_core.sv
// qkv_head_tile_address_generator_core: top level of the tile address generator
// depends on qkvg_pkg, qkvg_if, qkvg_div_pipe and qkvg_emit
//
// channel   dir   payload                                   handshake
// unit_ch   in    work_unit_index[31:0]                     valid/ready
// tile_ch   out   tile_index[31:0], part_kind[1:0], last    valid/ready
// cfg       in    cfg_index[1:0], cfg_wdata[15:0]           cfg_we, no wait
//
// a work unit is taken when the pipe moves and no register write holds it; it then passes
// the entry stage, 8 + 4 divider stages, 2 address stages, emitter load, output register.
// the emitter sets the pace: a unit gives tiles_per_head tile requests, three times as many
// when its head is first of its group, none when tiles_per_head is 0. arst_n clears all
// valid bits and loads the register reset values. a stall at tile_ch holds the emitter and
// then the whole pipe; unit_ch also waits during a register write and its settle hold.
module qkv_head_tile_address_generator_core #(
	parameter int MAX_HEAD_TILES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qkvg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qkvg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	qkvg_in_if.sink                           unit_ch,
	qkvg_out_if.source                        tile_ch
);

	localparam int DIV_STEP = 4;
	localparam int CFG_SETTLE = 2;

	// configuration registers
	logic [qkvg_pkg::PER_W-1:0] cfg_per_q;
	logic [qkvg_pkg::GRP_W-1:0] cfg_grp_q;
	logic [qkvg_pkg::TPH_W-1:0] cfg_tph_q;
	logic [qkvg_pkg::ROW_W-1:0] cfg_row_q;
	logic [1:0]                 cfg_hold_q;

	// derived configuration
	logic [qkvg_pkg::PER_W-1:0]   per_q;
	logic [qkvg_pkg::GRP_W-1:0]   grp_q;
	logic [qkvg_pkg::TPH_W-1:0]   tiles_q;
	logic [qkvg_pkg::HEADS_W-1:0] heads_q;
	logic [qkvg_pkg::QTOT_W-1:0]  qtot_q;
	logic [qkvg_pkg::KVTOT_W-1:0] kvtot_q;

	// pipeline
	logic                          adv;
	logic                          in_open;
	logic                          emit_ready;
	logic                          vld_s0;
	logic [qkvg_pkg::UNIT_W-1:0]   unit_s0;
	logic                          d1_valid;
	logic [qkvg_pkg::UNIT_W-1:0]   d1_block;
	logic [qkvg_pkg::HEADS_W-1:0]  d1_head;
	logic                          d2_valid;
	logic [qkvg_pkg::HEADS_W-1:0]  d2_quo;
	logic [qkvg_pkg::PER_W-1:0]    d2_rem;
	logic [qkvg_pkg::UNIT_W+qkvg_pkg::HEADS_W-1:0] d2_side;
	logic [qkvg_pkg::UNIT_W-1:0]   d2_block;
	logic [qkvg_pkg::HEADS_W-1:0]  d2_head;
	logic [qkvg_pkg::GRP_W-1:0]    d2_group;
	logic                          vld_s1;
	logic [qkvg_pkg::TILE_W-1:0]   base_s1;
	logic [qkvg_pkg::QTOT_W-1:0]   qofs_s1;
	logic [qkvg_pkg::KOFS_W-1:0]   kofs_s1;
	logic [qkvg_pkg::VOFS_W-1:0]   vofs_s1;
	logic                          first_s1;
	logic                          vld_s2;
	qkvg_pkg::emit_item_t          item_s2;
	logic [qkvg_pkg::KVTOT_W-1:0]  goff;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_per_q <= qkvg_pkg::RST_Q_HEADS_PER_GROUP;
			cfg_grp_q <= qkvg_pkg::RST_KV_GROUP_COUNT;
			cfg_tph_q <= qkvg_pkg::RST_TILES_PER_HEAD;
			cfg_row_q <= qkvg_pkg::RST_ROW_WIDTH_TILES;
		end else if (cfg_we) begin
			case (cfg_index)
				qkvg_pkg::REG_Q_HEADS_PER_GROUP: cfg_per_q <= cfg_wdata[qkvg_pkg::PER_W-1:0];
				qkvg_pkg::REG_KV_GROUP_COUNT:    cfg_grp_q <= cfg_wdata[qkvg_pkg::GRP_W-1:0];
				qkvg_pkg::REG_TILES_PER_HEAD:    cfg_tph_q <= cfg_wdata[qkvg_pkg::TPH_W-1:0];
				qkvg_pkg::REG_ROW_WIDTH_TILES:   cfg_row_q <= cfg_wdata[qkvg_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// hold off new requests until the derived totals follow a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hold_q <= '0;
		end else if (cfg_we) begin
			cfg_hold_q <= 2'(CFG_SETTLE);
		end else if (cfg_hold_q != '0) begin
			cfg_hold_q <= cfg_hold_q - 1'b1;
		end
	end

	// clamp counts, then register head and kv tile totals from them, q total from heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= qkvg_pkg::PER_W'(1);
			grp_q <= qkvg_pkg::GRP_W'(1);
			tiles_q <= qkvg_pkg::TPH_W'(1);
			heads_q <= qkvg_pkg::HEADS_W'(1);
			qtot_q <= qkvg_pkg::QTOT_W'(1);
			kvtot_q <= qkvg_pkg::KVTOT_W'(1);
		end else begin
			per_q <= (cfg_per_q == '0) ? qkvg_pkg::PER_W'(1) : cfg_per_q;
			grp_q <= (cfg_grp_q == '0) ? qkvg_pkg::GRP_W'(1) : cfg_grp_q;
			tiles_q <= (32'(cfg_tph_q) > 32'(MAX_HEAD_TILES))
				? qkvg_pkg::TPH_W'(MAX_HEAD_TILES) : cfg_tph_q;
			heads_q <= qkvg_pkg::HEADS_W'(per_q) * qkvg_pkg::HEADS_W'(grp_q);
			qtot_q <= qkvg_pkg::QTOT_W'(heads_q) * qkvg_pkg::QTOT_W'(tiles_q);
			kvtot_q <= qkvg_pkg::KVTOT_W'(grp_q) * qkvg_pkg::KVTOT_W'(tiles_q);
		end
	end

	// whole pipe moves unless the last stage is blocked
	assign adv = !vld_s2 || emit_ready;
	assign in_open = !cfg_we && (cfg_hold_q == '0);
	assign unit_ch.ready = adv && in_open;

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= unit_ch.valid && in_open;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_s0 <= unit_ch.work_unit_index;
		end
	end

	// block and head: unit / heads, unit % heads
	qkvg_div_pipe #(
		.N    (qkvg_pkg::UNIT_W),
		.D    (qkvg_pkg::HEADS_W),
		.STEP (DIV_STEP),
		.SW   (1)
	) u_div_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s0),
		.dividend  (unit_s0),
		.divisor   (heads_q),
		.side_i    (1'b0),
		.out_valid (d1_valid),
		.quotient  (d1_block),
		.remainder (d1_head),
		.side_o    ()
	);

	// group and first flag: head / per, head % per
	qkvg_div_pipe #(
		.N    (qkvg_pkg::HEADS_W),
		.D    (qkvg_pkg::PER_W),
		.STEP (DIV_STEP),
		.SW   (qkvg_pkg::UNIT_W + qkvg_pkg::HEADS_W)
	) u_div_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d1_valid),
		.dividend  (d1_head),
		.divisor   (per_q),
		.side_i    ({d1_block, d1_head}),
		.out_valid (d2_valid),
		.quotient  (d2_quo),
		.remainder (d2_rem),
		.side_o    (d2_side)
	);

	assign d2_block = d2_side[qkvg_pkg::UNIT_W+qkvg_pkg::HEADS_W-1:qkvg_pkg::HEADS_W];
	assign d2_head = d2_side[qkvg_pkg::HEADS_W-1:0];
	assign d2_group = d2_quo[qkvg_pkg::GRP_W-1:0];
	assign goff = qkvg_pkg::KVTOT_W'(d2_group) * qkvg_pkg::KVTOT_W'(tiles_q);

	// stage 1: row base and offsets inside the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= qkvg_pkg::TILE_W'(d2_block * cfg_row_q);
			qofs_s1 <= qkvg_pkg::QTOT_W'(d2_head) * qkvg_pkg::QTOT_W'(tiles_q);
			kofs_s1 <= qkvg_pkg::KOFS_W'(qtot_q) + qkvg_pkg::KOFS_W'(goff);
			vofs_s1 <= qkvg_pkg::VOFS_W'(qtot_q) + qkvg_pkg::VOFS_W'(kvtot_q)
				+ qkvg_pkg::VOFS_W'(goff);
			first_s1 <= d2_rem == '0;
		end
	end

	// stage 2: run start tiles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2.q_start <= base_s1 + qkvg_pkg::TILE_W'(qofs_s1);
			item_s2.k_start <= base_s1 + qkvg_pkg::TILE_W'(kofs_s1);
			item_s2.v_start <= base_s1 + qkvg_pkg::TILE_W'(vofs_s1);
			item_s2.tiles <= tiles_q;
			item_s2.first <= first_s1;
		end
	end

	// tile run expansion
	qkvg_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.in_ready (emit_ready),
		.item     (item_s2),
		.tile_ch  (tile_ch)
	);

endmodule

### verif/qkv_head_tile_address_generator_core_tb.sv
`timescale 1ns / 1ps
// qkv_head_tile_address_generator_core_tb: self-checking bench that feeds work units,
// predicts the q/k/v tile runs of each and compares every tile request in order
// depends on qkvg_pkg, qkvg_if and qkv_head_tile_address_generator_core
module qkv_head_tile_address_generator_core_tb;

	localparam int MAX_HEAD_TILES = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SEGMENTS_PER_PHASE = 4;
	localparam int UNITS_PER_SEGMENT = 13;

	typedef struct packed {
		logic [qkvg_pkg::TILE_W-1:0] tile;
		qkvg_pkg::part_kind_t        kind;
		logic                        last;
	} tile_req_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [qkvg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [qkvg_pkg::CFG_DATA_W-1:0] cfg_wdata;

	qkvg_in_if  unit_if ();
	qkvg_out_if tile_if ();

	// shadow of the configuration registers
	logic [qkvg_pkg::PER_W-1:0] cur_per;
	logic [qkvg_pkg::GRP_W-1:0] cur_grp;
	logic [qkvg_pkg::TPH_W-1:0] cur_tph;
	logic [qkvg_pkg::ROW_W-1:0] cur_row;

	tile_req_t pending_tiles[$];
	int        mismatch_count;
	int        src_idle_pct;
	int        sink_idle_pct;
	int        cycle_count;

	qkv_head_tile_address_generator_core #(
		.MAX_HEAD_TILES(MAX_HEAD_TILES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.unit_ch(unit_if),
		.tile_ch(tile_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected tile runs of one work unit under the current configuration
	function automatic void compute_unit_tiles(input logic [qkvg_pkg::UNIT_W-1:0] unit);
		logic [31:0] per;
		logic [31:0] groups;
		logic [31:0] tiles;
		logic [31:0] heads;
		logic [31:0] blk;
		logic [31:0] head;
		logic [31:0] grp;
		logic [31:0] base;
		logic [31:0] q_total;
		logic [31:0] kv_total;
		logic        first_head;
		int          start_size;
		start_size = pending_tiles.size();
		per = (cur_per == '0) ? 32'd1 : 32'(cur_per);
		groups = (cur_grp == '0) ? 32'd1 : 32'(cur_grp);
		tiles = (cur_tph > MAX_HEAD_TILES) ? 32'(MAX_HEAD_TILES) : 32'(cur_tph);
		heads = per * groups;
		blk = unit / heads;
		head = unit % heads;
		grp = head / per;
		first_head = (head % per) == 32'd0;
		base = blk * 32'(cur_row);
		q_total = heads * tiles;
		kv_total = groups * tiles;
		for (int i = 0; i < tiles; i++)
			pending_tiles.push_back('{tile: base + head * tiles + 32'(i),
				kind: qkvg_pkg::PART_Q, last: 1'b0});
		if (first_head) begin
			for (int i = 0; i < tiles; i++)
				pending_tiles.push_back('{tile: base + q_total + grp * tiles + 32'(i),
					kind: qkvg_pkg::PART_K, last: 1'b0});
			for (int i = 0; i < tiles; i++)
				pending_tiles.push_back('{tile: base + q_total + kv_total + grp * tiles
					+ 32'(i), kind: qkvg_pkg::PART_V, last: 1'b0});
		end
		if (pending_tiles.size() > start_size)
			pending_tiles[pending_tiles.size() - 1].last = 1'b1;
	endfunction

	// tile request checker with random backpressure
	initial begin
		tile_req_t exp_req;
		tile_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (tile_if.valid && tile_if.ready) begin
				if (pending_tiles.size() == 0) begin
					mismatch_count++;
					$display("%0t: extra request: expected none, actual %0d/%0d/%0b",
						$time, tile_if.tile_index, tile_if.part_kind, tile_if.last_of_run);
				end else begin
					exp_req = pending_tiles.pop_front();
					if (tile_if.tile_index !== exp_req.tile ||
							tile_if.part_kind !== exp_req.kind ||
							tile_if.last_of_run !== exp_req.last) begin
						mismatch_count++;
						$display("%0t: mismatch: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
							$time, exp_req.tile, exp_req.kind, exp_req.last,
							tile_if.tile_index, tile_if.part_kind, tile_if.last_of_run);
					end
				end
			end
			tile_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("qkv_head_tile_address_generator_core_tb failed");
		$finish;
	end

	// one work unit request, with random idle cycles ahead of it
	task automatic send_unit(input logic [qkvg_pkg::UNIT_W-1:0] unit);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			unit_if.valid <= 1'b0;
			@(posedge clk);
		end
		unit_if.valid <= 1'b1;
		unit_if.work_unit_index <= unit;
		do @(posedge clk); while (!unit_if.ready);
		compute_unit_tiles(unit);
	endtask

	// let every expected tile come out, then let the pipe settle
	task automatic wait_idle();
		unit_if.valid <= 1'b0;
		while (pending_tiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [qkvg_pkg::CFG_IDX_W-1:0] idx,
			input logic [qkvg_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// write all four registers; unused upper data bits carry junk
	task automatic set_config(input logic [qkvg_pkg::PER_W-1:0] per,
			input logic [qkvg_pkg::GRP_W-1:0] grp,
			input logic [qkvg_pkg::TPH_W-1:0] tph, input logic [qkvg_pkg::ROW_W-1:0] row);
		logic [qkvg_pkg::CFG_DATA_W-1:0] junk;
		junk = qkvg_pkg::CFG_DATA_W'($urandom);
		write_reg(qkvg_pkg::REG_Q_HEADS_PER_GROUP,
			{junk[qkvg_pkg::CFG_DATA_W-1:qkvg_pkg::PER_W], per});
		write_reg(qkvg_pkg::REG_KV_GROUP_COUNT,
			{junk[qkvg_pkg::CFG_DATA_W-1:qkvg_pkg::GRP_W], grp});
		write_reg(qkvg_pkg::REG_TILES_PER_HEAD,
			{junk[qkvg_pkg::CFG_DATA_W-1:qkvg_pkg::TPH_W], tph});
		write_reg(qkvg_pkg::REG_ROW_WIDTH_TILES, row);
		cfg_we <= 1'b0;
		cur_per = per;
		cur_grp = grp;
		cur_tph = tph;
		cur_row = row;
	endtask

	// head count for random configs: mostly small, sometimes zero or past the range
	function automatic logic [qkvg_pkg::PER_W-1:0] pick_count();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 7'd64;
			2: return 7'd127;
			3: return 7'($urandom_range(65, 127));
			4, 5: return 7'($urandom_range(1, 64));
			default: return 7'($urandom_range(1, 4));
		endcase
	endfunction

	// reset register values: one head, one tile, row of three
	task automatic test_reset_config();
		send_unit(32'd0);
		send_unit(32'd1);
		send_unit(32'hFFFF_FFFF);
		send_unit(32'h5555_5555);
		wait_idle();
	endtask

	// largest in-range config: full 48-tile runs and wrapping block bases
	task automatic test_head_extremes();
		set_config(7'd64, 7'd64, 5'd16, 16'hFFFF);
		send_unit(32'd0);
		send_unit(32'd64);
		send_unit(32'd4095);
		send_unit(32'd4096);
		send_unit(32'hFFFF_FFFF);
		send_unit(32'hAAAA_AAAA);
		wait_idle();
	endtask

	task automatic test_open_cases();
		// zero head counts act as one
		set_config('0, '0, 5'd3, 16'd5);
		send_unit(32'd0);
		send_unit(32'd7);
		wait_idle();
		// counts past the range, tiles per head saturating
		set_config(7'd127, 7'd127, 5'd31, 16'd1000);
		send_unit(32'd127);
		send_unit(32'd16128);
		send_unit(32'hFFFF_FFFF);
		wait_idle();
		// zero row width keeps every block at tile zero
		set_config(7'd3, 7'd2, 5'd2, 16'd0);
		send_unit(32'd5);
		send_unit(32'd6);
		send_unit(32'd100);
		wait_idle();
		// zero tiles per head yields no tiles at all
		set_config(7'd2, 7'd2, '0, 16'd9);
		send_unit(32'd0);
		send_unit(32'd3);
		wait_idle();
	endtask

	// random configs, each followed by a burst of random work units
	task automatic test_random_traffic(input int src_pct, input int sink_pct);
		logic [qkvg_pkg::PER_W-1:0] per;
		logic [qkvg_pkg::GRP_W-1:0] grp;
		logic [qkvg_pkg::TPH_W-1:0] tph;
		logic [qkvg_pkg::ROW_W-1:0] row;
		int                         heads;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (int s = 0; s < SEGMENTS_PER_PHASE; s++) begin
			per = pick_count();
			grp = pick_count();
			case ($urandom_range(0, 9))
				0: tph = '0;
				1: tph = 5'd16;
				2: tph = 5'($urandom_range(17, 31));
				default: tph = 5'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 5))
				0: row = '0;
				1: row = 16'hFFFF;
				default: row = 16'($urandom);
			endcase
			set_config(per, grp, tph, row);
			heads = ((per == '0) ? 1 : int'(per)) * ((grp == '0) ? 1 : int'(grp));
			for (int i = 0; i < UNITS_PER_SEGMENT; i++) begin
				if ($urandom_range(0, 1) == 0)
					send_unit(32'($urandom));
				else
					send_unit(32'($urandom_range(0, 8 * heads)));
			end
			wait_idle();
		end
	endtask

	// reset, directed tests, then three random phases with different idling
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		unit_if.valid = 1'b0;
		unit_if.work_unit_index = '0;
		mismatch_count = 0;
		src_idle_pct = 29;
		sink_idle_pct = 70;
		cur_per = qkvg_pkg::RST_Q_HEADS_PER_GROUP;
		cur_grp = qkvg_pkg::RST_KV_GROUP_COUNT;
		cur_tph = qkvg_pkg::RST_TILES_PER_HEAD;
		cur_row = qkvg_pkg::RST_ROW_WIDTH_TILES;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_head_extremes();
		test_open_cases();
		test_random_traffic(29, 70);
		test_random_traffic(70, 29);
		test_random_traffic(0, 0);

		if (mismatch_count == 0 && pending_tiles.size() == 0)
			$display("qkv_head_tile_address_generator_core_tb passed");
		else
			$display("qkv_head_tile_address_generator_core_tb failed");
		$finish;
	end

endmodule
